@@ rtl/core/framebuffer_rect_line_fill_core_assert.svh @@
// Assertion macros for the fill core; clocked on i_clk, off while i_rst_n is low.
`ifndef FRAMEBUFFER_RECT_LINE_FILL_CORE_ASSERT_SVH
`define FRAMEBUFFER_RECT_LINE_FILL_CORE_ASSERT_SVH

// Same-cycle implication.
`define FBRLF_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("fill core assertion failed");

// Next-cycle implication.
`define FBRLF_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("fill core assertion failed");

`endif

@@ rtl/core/fbrlf_pkg.sv @@
`default_nettype none

package fbrlf_pkg;

    localparam int X_W   = 10;
    localparam int Y_W   = 9;
    localparam int CMD_W = 3;
    localparam int COL_W = 3;
    localparam int PIX_W = 16;

    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 24;

    localparam logic [CMD_W-1:0] CMD_BG    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_RECT  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_HLINE = 3'd2;
    localparam logic [CMD_W-1:0] CMD_VLINE = 3'd3;
    localparam logic [CMD_W-1:0] CMD_READ  = 3'd4;

    localparam logic [COL_W-1:0] COL_BLACK  = 3'd0;
    localparam logic [COL_W-1:0] COL_RED    = 3'd1;
    localparam logic [COL_W-1:0] COL_YELLOW = 3'd2;
    localparam logic [COL_W-1:0] COL_GREEN  = 3'd3;
    localparam logic [COL_W-1:0] COL_BLUE   = 3'd4;

    localparam logic [PIX_W-1:0] PIX_BLACK  = 16'h0000;
    localparam logic [PIX_W-1:0] PIX_RED    = 16'hF800;
    localparam logic [PIX_W-1:0] PIX_GREEN  = 16'h07E0;
    localparam logic [PIX_W-1:0] PIX_BLUE   = 16'h001F;
    localparam logic [PIX_W-1:0] PIX_YELLOW = PIX_RED | PIX_GREEN;

    // Command to the raster walker: load a new span or advance one pixel.
    typedef struct packed {
        logic           load;
        logic           step;
        logic [X_W-1:0] x0;
        logic [X_W-1:0] x1;
        logic [Y_W-1:0] y0;
        logic [Y_W-1:0] y1;
    } t_walk_cmd;

    function automatic logic [PIX_W-1:0] color_to_pix(input logic [COL_W-1:0] code);
        logic [PIX_W-1:0] pix;
        case (code)
            COL_RED:    pix = PIX_RED;
            COL_YELLOW: pix = PIX_YELLOW;
            COL_GREEN:  pix = PIX_GREEN;
            COL_BLUE:   pix = PIX_BLUE;
            default:    pix = PIX_BLACK;
        endcase
        return pix;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/fbrlf_ram.sv @@
`default_nettype none

module fbrlf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 307200,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_addr,
    input  wire logic [WIDTH-1:0] i_wdata,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ rtl/core/fbrlf_walk.sv @@
`default_nettype none

// Raster walker: steps a row-major address over [x0,x1) x [y0,y1).
module fbrlf_walk #(
    parameter int FRAME_WIDTH = 640,
    parameter int ADDR_W      = 19
) (
    input  wire logic                  i_clk,
    input  wire fbrlf_pkg::t_walk_cmd  i_cmd,
    output logic [ADDR_W-1:0]          o_addr,
    output logic                       o_last
);

    localparam logic [ADDR_W-1:0] ROW_STEP = ADDR_W'(FRAME_WIDTH);

    logic [fbrlf_pkg::X_W-1:0] r_x, r_x0, r_x1;
    logic [fbrlf_pkg::Y_W-1:0] r_y, r_y1;
    logic [ADDR_W-1:0]         r_base;
    logic [fbrlf_pkg::X_W-1:0] x_inc;
    logic [fbrlf_pkg::Y_W-1:0] y_inc;
    logic                      row_end;

    assign x_inc   = r_x + 1'b1;
    assign y_inc   = r_y + 1'b1;
    assign row_end = (x_inc == r_x1);
    assign o_last  = row_end && (y_inc == r_y1);
    assign o_addr  = r_base + ADDR_W'(r_x);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x    <= i_cmd.x0;
            r_x0   <= i_cmd.x0;
            r_x1   <= i_cmd.x1;
            r_y    <= i_cmd.y0;
            r_y1   <= i_cmd.y1;
            r_base <= ADDR_W'(i_cmd.y0) * ROW_STEP;
        end else if (i_cmd.step) begin
            if (row_end) begin
                // wrap to the next row
                r_x    <= r_x0;
                r_y    <= y_inc;
                r_base <= r_base + ROW_STEP;
            end else begin
                r_x <= x_inc;
            end
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/framebuffer_rect_line_fill_core.sv @@
// RGB565 rectangle / line fill engine over an on-chip frame store.
// Input channel s_*: one command word per handshake (cmd in s_tuser, coordinates
// and color code in s_tdata). Output channel m_*: exactly one result word per
// command, pixel_value and bad_color in m_tdata.
// One command at a time: s_tready is high only while the engine is idle. A
// fill of N pixels writes one pixel per cycle through the single RAM port
// (state FILL), then passes to FIN, which loads the output register. A pixel
// read goes through RD and RDW (registered RAM read) to FIN; empty fills, bad
// color codes and unknown commands go straight to FIN. The engine is ready
// again in the same cycle that the result word shows on m_tvalid.
// The output register parts the two sides: the next command is accepted while
// a result still waits. If the receiver stalls, the finished result of that
// next command is held inside until the register frees up.
// Reset: the engine sweeps the frame store to black and accepts no command
// during the sweep.
`default_nettype none

`include "framebuffer_rect_line_fill_core_assert.svh"

module framebuffer_rect_line_fill_core #(
    parameter int FRAME_WIDTH  = 640,
    parameter int FRAME_HEIGHT = 480
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 s_tvalid,
    output logic                                      s_tready,
    // x_start[9:0], x_end[19:10], y_start[28:20], y_end[37:29],
    // color_code[40:38], zero pad above
    input  wire logic [fbrlf_pkg::IN_DATA_W-1:0]      s_tdata,
    // cmd[2:0]
    input  wire logic [fbrlf_pkg::CMD_W-1:0]          s_tuser,
    output logic                                      m_tvalid,
    input  wire logic                                 m_tready,
    // pixel_value[15:0], bad_color[16], zero pad above
    output logic [fbrlf_pkg::OUT_DATA_W-1:0]          m_tdata
);

    localparam int DEPTH  = FRAME_WIDTH * FRAME_HEIGHT;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int X_W    = fbrlf_pkg::X_W;
    localparam int Y_W    = fbrlf_pkg::Y_W;
    localparam int PIX_W  = fbrlf_pkg::PIX_W;
    localparam logic [X_W-1:0] W_X = X_W'(FRAME_WIDTH);
    localparam logic [Y_W-1:0] H_Y = Y_W'(FRAME_HEIGHT);

    typedef enum logic [5:0] {
        ST_INIT = 6'b000001,
        ST_IDLE = 6'b000010,
        ST_FILL = 6'b000100,
        ST_RD   = 6'b001000,
        ST_RDW  = 6'b010000,
        ST_FIN  = 6'b100000
    } t_state;

    t_state r_state, n_state;

    logic             r_clr, n_clr;
    logic [PIX_W-1:0] r_color, n_color;
    logic [PIX_W-1:0] r_res_pix, n_res_pix;
    logic             r_res_bad, n_res_bad;
    logic [PIX_W-1:0] r_out_pix, n_out_pix;
    logic             r_out_bad, n_out_bad;
    logic             r_out_vld, n_out_vld;

    // command fields
    logic [fbrlf_pkg::CMD_W-1:0] f_cmd;
    logic [X_W-1:0]              f_xs, f_xe;
    logic [Y_W-1:0]              f_ys, f_ye;
    logic [fbrlf_pkg::COL_W-1:0] f_code;

    // clipped span of the drawing command
    logic [X_W-1:0] sp_x0, sp_x1;
    logic [Y_W-1:0] sp_y0, sp_y1;
    logic           sp_empty;

    logic                 w_acc;
    logic                 w_we;
    logic [ADDR_W-1:0]    w_addr;
    logic                 w_last;
    logic [PIX_W-1:0]     w_rdata;
    fbrlf_pkg::t_walk_cmd w_walk;

    assign f_cmd  = s_tuser;
    assign f_xs   = s_tdata[9:0];
    assign f_xe   = s_tdata[19:10];
    assign f_ys   = s_tdata[28:20];
    assign f_ye   = s_tdata[37:29];
    assign f_code = s_tdata[40:38];

    assign s_tready = (r_state == ST_IDLE);
    assign w_acc    = s_tvalid && s_tready;
    assign w_we     = (r_state == ST_FILL);

    // Clip the span per command; a line off the frame comes out empty.
    always_comb begin
        sp_x0 = f_xs;
        sp_y0 = f_ys;
        sp_x1 = (f_xe < W_X) ? f_xe : W_X;
        sp_y1 = (f_ye < H_Y) ? f_ye : H_Y;
        case (f_cmd)
            fbrlf_pkg::CMD_BG: begin
                sp_x0 = '0;
                sp_y0 = '0;
                sp_x1 = W_X;
                sp_y1 = H_Y;
            end
            fbrlf_pkg::CMD_HLINE: begin
                sp_y1 = (f_ys < H_Y) ? (f_ys + 1'b1) : H_Y;
            end
            fbrlf_pkg::CMD_VLINE: begin
                sp_x1 = (f_xs < W_X) ? (f_xs + 1'b1) : W_X;
            end
            default: begin
            end
        endcase
        sp_empty = (sp_x0 >= sp_x1) || (sp_y0 >= sp_y1);
    end

    always_comb begin
        n_state   = r_state;
        n_clr     = r_clr;
        n_color   = r_color;
        n_res_pix = r_res_pix;
        n_res_bad = r_res_bad;
        n_out_pix = r_out_pix;
        n_out_bad = r_out_bad;
        n_out_vld = r_out_vld;
        w_walk    = '{load: 1'b0, step: 1'b0, x0: sp_x0, x1: sp_x1, y0: sp_y0, y1: sp_y1};

        // drop the result word once taken
        if (r_out_vld && m_tready) begin
            n_out_vld = 1'b0;
        end

        unique case (r_state)
            ST_INIT: begin
                // sweep the whole frame to black
                w_walk  = '{load: 1'b1, step: 1'b0, x0: '0, x1: W_X, y0: '0, y1: H_Y};
                n_color = fbrlf_pkg::PIX_BLACK;
                n_clr   = 1'b1;
                n_state = ST_FILL;
            end
            ST_IDLE: begin
                if (w_acc) begin
                    n_clr     = 1'b0;
                    n_res_pix = '0;
                    n_res_bad = 1'b0;
                    n_color   = fbrlf_pkg::color_to_pix(f_code);
                    n_state   = ST_FIN;
                    unique case (f_cmd) inside
                        fbrlf_pkg::CMD_BG, fbrlf_pkg::CMD_RECT,
                        fbrlf_pkg::CMD_HLINE, fbrlf_pkg::CMD_VLINE: begin
                            if (f_code > fbrlf_pkg::COL_BLUE) begin
                                n_res_bad = 1'b1;
                            end else if (!sp_empty) begin
                                w_walk.load = 1'b1;
                                n_state     = ST_FILL;
                            end
                        end
                        fbrlf_pkg::CMD_READ: begin
                            if ((f_xs < W_X) && (f_ys < H_Y)) begin
                                w_walk.load = 1'b1;
                                w_walk.x0   = f_xs;
                                w_walk.y0   = f_ys;
                                n_state     = ST_RD;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_FILL: begin
                // write one pixel, advance the walker
                w_walk.step = 1'b1;
                if (w_last) begin
                    n_state = r_clr ? ST_IDLE : ST_FIN;
                end
            end
            ST_RD: begin
                n_state = ST_RDW;
            end
            ST_RDW: begin
                n_res_pix = w_rdata;
                n_state   = ST_FIN;
            end
            ST_FIN: begin
                // hold the result until the output register frees up
                if (!r_out_vld || m_tready) begin
                    n_out_pix = r_res_pix;
                    n_out_bad = r_res_bad;
                    n_out_vld = 1'b1;
                    n_state   = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_INIT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_INIT;
            r_clr     <= 1'b1;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_clr     <= n_clr;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_color   <= n_color;
        r_res_pix <= n_res_pix;
        r_res_bad <= n_res_bad;
        r_out_pix <= n_out_pix;
        r_out_bad <= n_out_bad;
    end

    fbrlf_walk #(
        .FRAME_WIDTH (FRAME_WIDTH),
        .ADDR_W      (ADDR_W)
    ) u_walk (
        .i_clk  (i_clk),
        .i_cmd  (w_walk),
        .o_addr (w_addr),
        .o_last (w_last)
    );

    fbrlf_ram #(
        .WIDTH (PIX_W),
        .DEPTH (DEPTH)
    ) u_frame (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_addr  (w_addr),
        .i_wdata (r_color),
        .o_rdata (w_rdata)
    );

    assign m_tvalid = r_out_vld;
    assign m_tdata  = {(fbrlf_pkg::OUT_DATA_W - PIX_W - 1)'(0), r_out_bad, r_out_pix};

    // writes stay inside the frame
    `FBRLF_ASSERT_IMP(a_wr_in_frame, w_we, 32'(w_addr) < 32'(DEPTH))
    // the last pixel of a span ends the fill
    `FBRLF_ASSERT_NXT(a_fill_ends, (r_state == ST_FILL) && w_last,
        (r_state == ST_IDLE) || (r_state == ST_FIN))
    // a free output register takes the finished result
    `FBRLF_ASSERT_NXT(a_fin_loads, (r_state == ST_FIN) && (!m_tvalid || m_tready),
        m_tvalid && (r_state == ST_IDLE))
    // the clearing sweep never produces a result word
    `FBRLF_ASSERT_IMP(a_clr_silent, (r_state == ST_FILL) && r_clr && w_last, !m_tvalid ||
        $past(m_tvalid))

endmodule

`default_nettype wire
